// ----- rtl/core/lvfc_pkg.sv -----
// ----------------------------------------------------------------------------
// lvfc_pkg
// Shared constants and helpers for the local variance flat classifier.
// ----------------------------------------------------------------------------
package lvfc_pkg;

  localparam int DEF_RADIUS    = 3;
  localparam int DEF_MAX_WIDTH = 1024;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic [10:0] RST_WIDTH     = 11'd128;
  localparam logic [12:0] RST_HEIGHT    = 13'd128;
  localparam logic [17:0] RST_THRESHOLD = 18'd1000;

  localparam int MAX_HEIGHT = 4096;

  // Half chord of the circular window for row offset dy
  function automatic int half_chord(input int dy, input int radius);
    int rem;
    int k;
    rem = radius * radius - dy * dy;
    k   = 0;
    for (int i = 1; i <= 8; i++) begin
      if (i * i <= rem) begin
        k = i;
      end
    end
    return k;
  endfunction

  // Center an occupancy value on 50; unknown counts as 0
  function automatic logic signed [6:0] to_centered(input logic signed [7:0] v);
    logic signed [6:0] u;
    if (v == -8'sd1) begin
      u = 7'sd0;
    end else if (v < 8'sd0) begin
      u = -7'sd50;
    end else if (v > 8'sd100) begin
      u = 7'sd50;
    end else begin
      u = 7'(v - 8'sd50);
    end
    return u;
  endfunction

endpackage

// ----- rtl/core/local_variance_flat_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// local_variance_flat_classifier_unit
// Flat/non-flat classification of occupancy cells over a circular window.
// ----------------------------------------------------------------------------
// Cells stream in raster order over an extended raster of (height+RADIUS-1)
// rows by (width+RADIUS-1) columns; cells past the image edge are padding and
// only advance the position. Each cell is centered (value-50, unknown as 0)
// and written into a line store of 2*RADIUS rows held in one synchronous
// memory. Once a window is complete, a sequencer sweeps the 2*RADIUS by
// 2*RADIUS square around it, one memory read per cycle, and sums count, sum
// and sum of squares of the cells in the circle and inside the image. Three
// registered steps then evaluate 100*(N*Q - S*S) < threshold*N*N. An item
// that causes no result leaves the input ready; one that causes a result
// holds the input off through the sweep and the evaluation, as the line
// store has a single read port. The result sits in an output register, so
// the next cell is taken while the result waits. Writing width or height
// restarts the frame; the input holds off while a register write lands.
// ----------------------------------------------------------------------------
module local_variance_flat_classifier_unit #(
  parameter int RADIUS    = lvfc_pkg::DEF_RADIUS,
  parameter int MAX_WIDTH = lvfc_pkg::DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  // input cell stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] cell_value
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] is_flat, [7:1] zero
  output logic        m_tlast,   // last_cell
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ROWS = 2 * RADIUS;
  localparam int MW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = $clog2(MAX_WIDTH + RADIUS);
  localparam int RW   = $clog2(lvfc_pkg::MAX_HEIGHT + RADIUS);
  localparam int NW   = $clog2(4 * RADIUS * RADIUS + 1);
  localparam int SW   = $clog2(50 * 4 * RADIUS * RADIUS + 1) + 1;
  localparam int QW   = $clog2(2500 * 4 * RADIUS * RADIUS + 1);
  localparam int PW   = NW + QW;
  localparam int LW   = PW + 7;
  localparam int RHW  = 18 + 2 * NW;
  localparam int CMW  = (LW > RHW) ? LW : RHW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Configuration registers
  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [17:0] flat_threshold_ppm;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      lvfc_pkg::REG_WIDTH:     prdata = {21'd0, image_width};
      lvfc_pkg::REG_HEIGHT:    prdata = {19'd0, image_height};
      lvfc_pkg::REG_THRESHOLD: prdata = {14'd0, flat_threshold_ppm};
      default:                 prdata = 32'd0;
    endcase
  end

  // Effective geometry: zero acts as one, width clamps at MAX_WIDTH
  logic [WW-1:0] weff;
  logic [12:0]   heff;
  always_comb begin
    if (image_width == 11'd0) begin
      weff = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      weff = WW'(MAX_WIDTH);
    end else begin
      weff = WW'(image_width);
    end
    heff = (image_height == 13'd0) ? 13'd1 : image_height;
  end

  // Position and sequencer state
  logic [2:0]    state;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [MW-1:0] wrow;
  logic          accept;
  logic          in_image;
  logic          has_result;
  logic          is_last;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [MW-1:0] wrow_next;

  // Hold the input off while a register write lands
  assign s_tready = (state == ST_IDLE) && !cfg_wr;
  assign accept   = s_tvalid && s_tready;
  assign in_image = (32'(row) < 32'(heff)) && (32'(col) < 32'(weff));
  assign has_result = (32'(row) >= RADIUS - 1) && (32'(col) >= RADIUS - 1);
  assign is_last  = (32'(row) == 32'(heff) + RADIUS - 2) &&
                    (32'(col) == 32'(weff) + RADIUS - 2);

  always_comb begin
    col_next  = col + CW'(1);
    row_next  = row;
    wrow_next = wrow;
    if (32'(col) + 1 >= 32'(weff) + RADIUS - 1) begin
      col_next = '0;
      row_next = row + RW'(1);
      wrow_next = (32'(wrow) == ROWS - 1) ? '0 : wrow + MW'(1);
      if (32'(row) + 1 >= 32'(heff) + RADIUS - 1) begin
        row_next  = '0;
        wrow_next = '0;
      end
    end
  end

  // Sweep of the window square
  logic [MW-1:0]         t_cnt;
  logic [MW-1:0]         x_cnt;
  logic [MW-1:0]         ymod;
  logic signed [RW+1:0]  y_cur;
  logic signed [CW+1:0]  x_base;
  logic signed [CW+1:0]  x_rd;
  logic                  last_q;
  int                    kt;
  logic                  in_chord;
  logic                  y_ok;
  logic                  x_ok;
  logic                  rd_ok;
  logic                  scan_end;

  assign x_rd = x_base + $signed({{(CW+2-MW){1'b0}}, x_cnt});
  always_comb begin
    kt       = lvfc_pkg::half_chord(int'(t_cnt) - RADIUS, RADIUS);
    in_chord = (int'(x_cnt) >= RADIUS - kt) && (int'(x_cnt) < RADIUS + kt);
    y_ok     = !y_cur[RW+1] && (y_cur < $signed({{(RW-11){1'b0}}, heff}));
    x_ok     = !x_rd[CW+1] && (x_rd < $signed({{(CW+2-WW){1'b0}}, weff}));
    rd_ok    = (state == ST_SCAN) && in_chord && y_ok && x_ok;
    scan_end = (32'(t_cnt) == ROWS - 1) && (32'(x_cnt) == ROWS - 1);
  end

  // Line store: one write at accept, one registered read per sweep cycle
  logic signed [6:0] line_store [ROWS][MAX_WIDTH];
  logic signed [6:0] rdata;
  logic              acc_en;

  always_ff @(posedge clk) begin
    if (accept && in_image) begin
      line_store[wrow][col[XW-1:0]] <= lvfc_pkg::to_centered(s_tdata);
    end
    rdata <= line_store[ymod][x_rd[XW-1:0]];
  end

  // Accumulators
  logic [NW-1:0]        n_acc;
  logic signed [SW-1:0] s_acc;
  logic [QW-1:0]        q_acc;
  logic [13:0]          usq;
  assign usq = 14'(rdata * rdata);

  // Product and comparison registers
  logic [PW-1:0]      nq;
  logic [2*SW-1:0]    ss;
  logic [2*NW-1:0]    nn;
  logic [CMW-1:0]     lhs;
  logic [CMW-1:0]     rhs;
  logic               n_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      col                <= '0;
      row                <= '0;
      wrow               <= '0;
      acc_en             <= 1'b0;
      m_tvalid           <= 1'b0;
      image_width        <= lvfc_pkg::RST_WIDTH;
      image_height       <= lvfc_pkg::RST_HEIGHT;
      flat_threshold_ppm <= lvfc_pkg::RST_THRESHOLD;
    end else begin
      acc_en <= rd_ok;
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      // Geometry writes restart the frame
      if (cfg_wr) begin
        unique case (paddr[3:2])
          lvfc_pkg::REG_WIDTH: begin
            image_width <= pwdata[10:0];
            col <= '0;
            row <= '0;
            wrow <= '0;
          end
          lvfc_pkg::REG_HEIGHT: begin
            image_height <= pwdata[12:0];
            col <= '0;
            row <= '0;
            wrow <= '0;
          end
          lvfc_pkg::REG_THRESHOLD: flat_threshold_ppm <= pwdata[17:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            col  <= col_next;
            row  <= row_next;
            wrow <= wrow_next;
            if (has_result) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: state <= ST_MUL;
        ST_MUL:   state <= ST_SCALE;
        ST_SCALE: state <= ST_DONE;
        ST_DONE: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      t_cnt  <= '0;
      x_cnt  <= '0;
      ymod   <= (32'(wrow) == ROWS - 1) ? '0 : wrow + MW'(1);
      y_cur  <= $signed({2'b00, row}) - $signed((RW+2)'(ROWS - 1));
      x_base <= $signed({2'b00, col}) - $signed((CW+2)'(ROWS - 1));
      last_q <= is_last;
      n_acc  <= '0;
      s_acc  <= '0;
      q_acc  <= '0;
    end else begin
      if (state == ST_SCAN) begin
        // Advance along the row, then to the next stored row
        if (32'(x_cnt) == ROWS - 1) begin
          x_cnt <= '0;
          t_cnt <= t_cnt + MW'(1);
          y_cur <= y_cur + (RW+2)'(1);
          ymod  <= (32'(ymod) == ROWS - 1) ? '0 : ymod + MW'(1);
        end else begin
          x_cnt <= x_cnt + MW'(1);
        end
      end
      if (acc_en) begin
        n_acc <= n_acc + NW'(1);
        s_acc <= s_acc + SW'(rdata);
        q_acc <= q_acc + QW'(usq);
      end
    end
    if (state == ST_MUL) begin
      nq     <= PW'(n_acc) * PW'(q_acc);
      ss     <= (2*SW)'(s_acc * s_acc);
      nn     <= (2*NW)'(n_acc) * (2*NW)'(n_acc);
      n_zero <= (n_acc == '0);
    end
    if (state == ST_SCALE) begin
      lhs <= CMW'(nq - PW'(ss)) * CMW'(100);
      rhs <= CMW'(flat_threshold_ppm) * CMW'(nn);
    end
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {7'd0, n_zero || (lhs < rhs)};
      m_tlast <= last_q;
    end
  end

endmodule

// ----- rtl/core/lvfc_checker.sv -----
// ----------------------------------------------------------------------------
// lvfc_checker
// Port-level checks for the local variance flat classifier.
// ----------------------------------------------------------------------------
module lvfc_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       pready
);

  // A stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result dropped or changed under stall");

  // Only the flat bit is ever set
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:1] == 7'd0)
    else $error("padding bits of result set");

  // Configuration port never waits
  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind local_variance_flat_classifier_unit lvfc_checker u_lvfc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .pready   (pready)
);

// ----- tb/sv/lvfc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvfc_scoreboard
// Watches the cell, result and register channels of the flat classifier,
// predicts each result from its own copy of the line store and compares.
// ----------------------------------------------------------------------------
module lvfc_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          pending,
  output int          errors
);

  localparam int R    = lvfc_pkg::DEF_RADIUS;
  localparam int MW   = lvfc_pkg::DEF_MAX_WIDTH;
  localparam int ROWS = 2 * R;

  typedef struct packed {
    logic flat;
    logic last_cell;
  } verdict_t;

  verdict_t          verdict_q[$];
  logic signed [6:0] offset_rows [ROWS][MW];
  logic [10:0]       width_reg;
  logic [12:0]       height_reg;
  logic [17:0]       thresh_reg;
  int                col_pos;
  int                row_pos;
  int                fail_count;

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MW) return MW;
    return width_reg;
  endfunction

  function automatic int eff_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  // widest dx reach in row offset dy of the circle
  function automatic int chord_reach(input int dy);
    int k;
    k = 0;
    while ((k + 1) * (k + 1) <= R * R - dy * dy) k++;
    return k;
  endfunction

  function automatic logic signed [6:0] cell_offset(input logic signed [7:0] v);
    if (v == -8'sd1) return 7'sd0;
    if (v < 0) return -7'sd50;
    if (v > 8'sd100) return 7'sd50;
    return 7'(v - 8'sd50);
  endfunction

  task automatic classify_cell(input logic [7:0] raw);
    int w, h, ci, cj, y, x, k;
    longint n, s, q, u;
    verdict_t v;
    w = eff_width();
    h = eff_height();
    if (row_pos < h && col_pos < w) offset_rows[row_pos % ROWS][col_pos] = cell_offset(raw);
    if (row_pos >= R - 1 && col_pos >= R - 1) begin
      ci = row_pos - (R - 1);
      cj = col_pos - (R - 1);
      n = 0; s = 0; q = 0;
      for (int dy = -R; dy < R; dy++) begin
        y = ci + dy;
        if (y >= 0 && y < h) begin
          k = chord_reach(dy);
          for (int dx = -k; dx < k; dx++) begin
            x = cj + dx;
            if (x >= 0 && x < w) begin
              u = offset_rows[y % ROWS][x];
              n += 1;
              s += u;
              q += u * u;
            end
          end
        end
      end
      v.flat      = (n == 0) || (100 * (n * q - s * s) < longint'(thresh_reg) * n * n);
      v.last_cell = (ci == h - 1) && (cj == w - 1);
      verdict_q = {verdict_q, v};
    end
    col_pos++;
    if (col_pos >= w + R - 1) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h + R - 1) row_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    verdict_t e;
    if (rst) begin
      verdict_q.delete();
      width_reg  = lvfc_pkg::RST_WIDTH;
      height_reg = lvfc_pkg::RST_HEIGHT;
      thresh_reg = lvfc_pkg::RST_THRESHOLD;
      col_pos    = 0;
      row_pos    = 0;
      fail_count = 0;
    end else begin
      // register writes restart the frame on geometry changes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          lvfc_pkg::REG_WIDTH: begin
            width_reg = pwdata[10:0];
            col_pos = 0;
            row_pos = 0;
          end
          lvfc_pkg::REG_HEIGHT: begin
            height_reg = pwdata[12:0];
            col_pos = 0;
            row_pos = 0;
          end
          lvfc_pkg::REG_THRESHOLD: thresh_reg = pwdata[17:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with none expected: tdata=%h tlast=%b", $realtime,
                     m_tdata, m_tlast);
        end else begin
          e = verdict_q.pop_front();
          if (m_tdata !== {7'b0, e.flat} || m_tlast !== e.last_cell) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected flat=%b last=%b, got tdata=%h tlast=%b",
                       $realtime, e.flat, e.last_cell, m_tdata, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready) classify_cell(s_tdata);
    end
    pending <= verdict_q.size();
    errors  <= fail_count;
  end

endmodule

// ----- tb/sv/tb_local_variance_flat_classifier_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_local_variance_flat_classifier_unit
// Streams occupancy frames of many geometries and thresholds into the flat
// classifier with random gaps on both sides; a checker module predicts and
// compares every result, this top drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_local_variance_flat_classifier_unit;

  localparam int R          = lvfc_pkg::DEF_RADIUS;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = 100;

  // register index past the last register
  localparam logic [1:0] REG_NONE = 2'd3;

  localparam logic [7:0] DIRECTED [24] = '{
    8'h80, 8'h7F, 8'hFF, 8'h00, 8'h64, 8'h65, 8'hFE, 8'h32,
    8'h55, 8'hAA, 8'h01, 8'h63, 8'h32, 8'h32, 8'h32, 8'h00,
    8'h64, 8'hFF, 8'hFF, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  int pending;
  int errors;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  int cells_sent = 0;

  always #5 clk = ~clk;

  local_variance_flat_classifier_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lvfc_scoreboard checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .pending(pending), .errors(errors)
  );

  // Watchdog: end the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 19);
  endfunction

  // Result side: stall a random number of cycles before each result
  initial begin
    int g;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      g = draw_gap();
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Two-phase register write; lands at the edge with penable high
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Push one cell request, keeping tvalid high across back-to-back cells
  task automatic send_cell(input logic [7:0] v);
    int g;
    g = draw_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    cells_sent++;
  endtask

  // Drop valid and hold until every result is back, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_geometry(input int w, input int h);
    reg_write(lvfc_pkg::REG_WIDTH, 32'(w));
    reg_write(lvfc_pkg::REG_HEIGHT, 32'(h));
  endtask

  // Cell content by frame style: flat, near flat, busy, or out-of-range noise
  function automatic logic [7:0] pick_cell(input int style, input int base);
    case (style)
      0: return 8'(base);
      1: return 8'(base + $urandom_range(0, 4) - 2);
      2: return 8'($urandom_range(0, 100));
      default: begin
        case ($urandom_range(0, 3))
          0: return 8'hFF;
          1: return 8'($urandom);
          default: return 8'($urandom_range(0, 100));
        endcase
      end
    endcase
  endfunction

  task automatic send_frame_cells(input int count, input int style);
    int base;
    base = $urandom_range(0, 100);
    for (int n = 0; n < count; n++) send_cell(pick_cell(style, base));
  endtask

  function automatic logic [31:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd250000;
      2: return 32'h3FFFF;
      3: return 32'($urandom_range(0, 262143));
      default: return 32'($urandom_range(0, 5000));
    endcase
  endfunction

  initial begin
    int w, h, frame_cells, frames;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: 4x2 image with extreme and out-of-range values
    set_geometry(4, 2);
    reg_write(lvfc_pkg::REG_THRESHOLD, 32'd1000);
    foreach (DIRECTED[n]) send_cell(DIRECTED[n]);
    drain();

    // Width zero and height zero act as one; bad index must do nothing
    reg_write(REG_NONE, 32'hFFFF_FFFF);
    set_geometry(0, 0);
    reg_write(lvfc_pkg::REG_THRESHOLD, 32'd0);
    send_frame_cells(R * R, 3);
    send_frame_cells(R * R, 0);
    drain();

    // Oversized width clamps to the maximum; one row tall, start of a frame
    no_gaps = 1'b1;
    set_geometry(2047, 1);
    reg_write(lvfc_pkg::REG_THRESHOLD, 32'h3FFFF);
    send_frame_cells(R * R, 1);
    drain();

    // Tallest image, one column wide; top part of the frame
    set_geometry(1, lvfc_pkg::MAX_HEIGHT);
    reg_write(lvfc_pkg::REG_THRESHOLD, 32'd250000);
    send_frame_cells(20 * R, 2);
    drain();
    no_gaps = 1'b0;

    // Random phases of small frames; some cut short, some with a threshold
    // change in the middle of a frame
    while (cells_sent < 1000) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      set_geometry(w, h);
      reg_write(lvfc_pkg::REG_THRESHOLD, pick_threshold());
      frame_cells = (w + R - 1) * (h + R - 1);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        case ($urandom_range(0, 7))
          0: send_frame_cells($urandom_range(1, frame_cells - 1), 3);
          1: begin
            send_frame_cells(frame_cells / 2, 2);
            drain();
            reg_write(lvfc_pkg::REG_THRESHOLD, pick_threshold());
            send_frame_cells(frame_cells - frame_cells / 2, 2);
          end
          default: send_frame_cells(frame_cells, $urandom_range(0, 3));
        endcase
      end
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lvfc_pkg.sv
rtl/core/local_variance_flat_classifier_unit.sv
rtl/core/lvfc_checker.sv
tb/sv/lvfc_checker.sv
tb/sv/tb_local_variance_flat_classifier_unit.sv
